[rtl/core/bvhrf_pkg.sv]
package bvhrf_pkg;

    // command kinds carried on the input tuser
    localparam int KIND_W = 2;
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_VERTEX = 2'd0;
    localparam kind_t KIND_CORNER = 2'd1;
    localparam kind_t KIND_NODE   = 2'd2;
    localparam kind_t KIND_REFIT  = 2'd3;

    // field widths
    localparam int INDEX_W  = 14;
    localparam int COORD_W  = 32;
    localparam int LINK_W   = 13;
    localparam int COUNT_W  = 4;
    localparam int NODE_ID_W = 13;
    localparam int VTX_W    = 3 * COORD_W;
    localparam int BOX_W    = 6 * COORD_W;

    // packed stream widths, rounded to whole bytes
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 208;

    // triangle number and corner slot during a leaf walk
    localparam int TRI_W  = 14;
    localparam int SLOT_W = 16;
    localparam logic [1:0] LAST_CORNER = 2'd2;

    // empty box bounds
    localparam logic signed [COORD_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] EMPTY_MAX = 32'sh8000_0000;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic start;
        logic next_tri;
        logic corner_rd;
        logic vert_rd;
        logic grow_vert;
        logic next_corner;
        logic grow_child;
        logic child_b_rd;
        logic store;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_ok;
        logic leaf;
        logic tri_ok;
        logic tri_last;
        logic corner_last;
        logic vert_ok;
        logic a_ok;
        logic b_ok;
    } sts_t;

endpackage

[rtl/core/bvhrf_dp.sv]
module bvhrf_dp #(
    parameter int VERTEX_DEPTH   = 4096,
    parameter int TRIANGLE_DEPTH = 4096,
    parameter int NODE_DEPTH     = 8192,
    parameter int MAX_LEAF_TRIS  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bvhrf_pkg::cmd_t                     cmd,
    output bvhrf_pkg::sts_t                     sts,
    input  bvhrf_pkg::kind_t                    in_kind,
    input  logic [bvhrf_pkg::IN_DATA_W-1:0]     in_data,
    output logic [bvhrf_pkg::OUT_DATA_W-1:0]    out_data
);
    import bvhrf_pkg::*;

    localparam int CORNER_DEPTH = 3 * TRIANGLE_DEPTH;
    localparam int VA_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int CA_W = (CORNER_DEPTH > 1) ? $clog2(CORNER_DEPTH) : 1;
    localparam int NA_W = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_LEAF_TRIS + 1);
    localparam int LREC_W = 2 * LINK_W + CNT_W;

    // input fields
    logic [INDEX_W-1:0] in_index;
    logic [VTX_W-1:0]   in_pos;
    logic [LINK_W-1:0]  in_link_a;
    logic [LINK_W-1:0]  in_link_b;
    logic [COUNT_W-1:0] in_count;
    logic [CNT_W-1:0]   in_count_sat;

    assign in_index  = in_data[13:0];
    assign in_pos    = in_data[109:14];
    assign in_link_a = in_data[122:110];
    assign in_link_b = in_data[135:123];
    assign in_count  = in_data[139:136];
    assign in_count_sat = (32'(in_count) > MAX_LEAF_TRIS) ? CNT_W'(MAX_LEAF_TRIS)
                                                          : CNT_W'(in_count);

    // storage
    logic [VTX_W-1:0]  vtx_mem    [VERTEX_DEPTH];
    logic [LINK_W-1:0] corner_mem [CORNER_DEPTH];
    logic [LREC_W-1:0] link_mem   [NODE_DEPTH];
    logic [BOX_W-1:0]  box_mem    [NODE_DEPTH];

    logic [VTX_W-1:0]  vtx_rd_reg;
    logic [LINK_W-1:0] corner_rd_reg;
    logic [LREC_W-1:0] link_rd_reg;
    logic [BOX_W-1:0]  box_rd_reg;

    logic [INDEX_W-1:0] idx_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [1:0]         c_reg;
    logic signed [COORD_W-1:0] min_reg [3];
    logic signed [COORD_W-1:0] max_reg [3];
    logic [OUT_DATA_W-1:0] out_reg;

    logic [LINK_W-1:0] lk_a;
    logic [LINK_W-1:0] lk_b;
    logic [CNT_W-1:0]  lk_cnt;
    logic [TRI_W-1:0]  tri_num;
    logic [BOX_W-1:0]  box_word;

    assign lk_a   = link_rd_reg[LINK_W-1:0];
    assign lk_b   = link_rd_reg[2*LINK_W-1:LINK_W];
    assign lk_cnt = link_rd_reg[LREC_W-1:2*LINK_W];
    assign tri_num = TRI_W'(lk_a) + TRI_W'(k_reg);

    // write enables from an accepted transaction
    logic vtx_we;
    logic corner_we;
    logic link_we;

    assign vtx_we    = cmd.accept && (in_kind == KIND_VERTEX) &&
                       (32'(in_index) < VERTEX_DEPTH);
    assign corner_we = cmd.accept && (in_kind == KIND_CORNER) &&
                       (32'(in_index) < CORNER_DEPTH);
    assign link_we   = cmd.accept && (in_kind == KIND_NODE) &&
                       (32'(in_index) < NODE_DEPTH);

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            vtx_mem[VA_W'(in_index)] <= in_pos;
        end
        if (cmd.vert_rd)
        begin
            vtx_rd_reg <= vtx_mem[VA_W'(corner_rd_reg)];
        end
    end

    // corner memory
    always_ff @(posedge clk)
    begin
        if (corner_we)
        begin
            corner_mem[CA_W'(in_index)] <= in_link_a;
        end
        if (cmd.corner_rd)
        begin
            corner_rd_reg <= corner_mem[CA_W'(slot_reg)];
        end
    end

    // node record memory, read as each transaction is taken
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[NA_W'(in_index)] <= {in_count_sat, in_link_b, in_link_a};
        end
        if (cmd.accept)
        begin
            link_rd_reg <= link_mem[NA_W'(in_index)];
        end
    end

    // node box memory
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            box_mem[NA_W'(idx_reg)] <= box_word;
        end
        if (cmd.start)
        begin
            box_rd_reg <= box_mem[NA_W'(lk_a)];
        end
        else if (cmd.child_b_rd)
        begin
            box_rd_reg <= box_mem[NA_W'(lk_b)];
        end
    end

    // leaf walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            k_reg    <= '0;
            c_reg    <= '0;
        end
        else if (cmd.start)
        begin
            slot_reg <= SLOT_W'({lk_a, 1'b0}) + SLOT_W'(lk_a);
            k_reg    <= '0;
            c_reg    <= '0;
        end
        else if (cmd.next_tri)
        begin
            slot_reg <= slot_reg + SLOT_W'(3);
            k_reg    <= k_reg + 1'b1;
        end
        else if (cmd.next_corner)
        begin
            slot_reg <= slot_reg + 1'b1;
            if (c_reg == LAST_CORNER)
            begin
                c_reg <= '0;
                k_reg <= k_reg + 1'b1;
            end
            else
            begin
                c_reg <= c_reg + 1'b1;
            end
        end
    end

    // refit index capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= in_index;
        end
    end

    // box accumulation, one compare per axis and bound
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.start)
            begin
                min_reg[i] <= EMPTY_MIN;
                max_reg[i] <= EMPTY_MAX;
            end
            else if (cmd.grow_vert)
            begin
                if ($signed(vtx_rd_reg[i*COORD_W +: COORD_W]) < min_reg[i])
                begin
                    min_reg[i] <= $signed(vtx_rd_reg[i*COORD_W +: COORD_W]);
                end
                if ($signed(vtx_rd_reg[i*COORD_W +: COORD_W]) > max_reg[i])
                begin
                    max_reg[i] <= $signed(vtx_rd_reg[i*COORD_W +: COORD_W]);
                end
            end
            else if (cmd.grow_child)
            begin
                if ($signed(box_rd_reg[i*COORD_W +: COORD_W]) < min_reg[i])
                begin
                    min_reg[i] <= $signed(box_rd_reg[i*COORD_W +: COORD_W]);
                end
                if ($signed(box_rd_reg[(i+3)*COORD_W +: COORD_W]) > max_reg[i])
                begin
                    max_reg[i] <= $signed(box_rd_reg[(i+3)*COORD_W +: COORD_W]);
                end
            end
        end
    end

    assign box_word = {max_reg[2], max_reg[1], max_reg[0],
                       min_reg[2], min_reg[1], min_reg[0]};

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            out_reg <= {3'b000, box_word, idx_reg[NODE_ID_W-1:0]};
        end
    end

    assign out_data = out_reg;

    // status
    assign sts.idx_ok      = 32'(idx_reg) < NODE_DEPTH;
    assign sts.leaf        = lk_cnt != '0;
    assign sts.tri_ok      = 32'(tri_num) < TRIANGLE_DEPTH;
    assign sts.tri_last    = (k_reg + 1'b1) == lk_cnt;
    assign sts.corner_last = sts.tri_last && (c_reg == LAST_CORNER);
    assign sts.vert_ok     = 32'(corner_rd_reg) < VERTEX_DEPTH;
    assign sts.a_ok        = 32'(lk_a) < NODE_DEPTH;
    assign sts.b_ok        = 32'(lk_b) < NODE_DEPTH;

endmodule

[rtl/core/bvhrf_ctrl.sv]
module bvhrf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bvhrf_pkg::kind_t  in_kind,
    output logic              out_valid,
    input  logic              out_ready,
    output bvhrf_pkg::cmd_t   cmd,
    input  bvhrf_pkg::sts_t   sts
);
    import bvhrf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LINK   = 3'd1;
    localparam logic [2:0] S_TRI    = 3'd2;
    localparam logic [2:0] S_VERT   = 3'd3;
    localparam logic [2:0] S_GROWV  = 3'd4;
    localparam logic [2:0] S_CHILDA = 3'd5;
    localparam logic [2:0] S_CHILDB = 3'd6;
    localparam logic [2:0] S_STORE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && (in_kind == KIND_REFIT))
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                if (!sts.idx_ok)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.leaf ? S_TRI : S_CHILDA;
                end
            end
            S_TRI:
            begin
                if (sts.tri_ok)
                begin
                    cmd.corner_rd = 1'b1;
                    state_next    = S_VERT;
                end
                else
                begin
                    cmd.next_tri = 1'b1;
                    state_next   = sts.tri_last ? S_STORE : S_TRI;
                end
            end
            S_VERT:
            begin
                if (sts.vert_ok)
                begin
                    cmd.vert_rd = 1'b1;
                    state_next  = S_GROWV;
                end
                else
                begin
                    cmd.next_corner = 1'b1;
                    state_next      = sts.corner_last ? S_STORE : S_TRI;
                end
            end
            S_GROWV:
            begin
                cmd.grow_vert   = 1'b1;
                cmd.next_corner = 1'b1;
                state_next      = sts.corner_last ? S_STORE : S_TRI;
            end
            S_CHILDA:
            begin
                cmd.grow_child = sts.a_ok;
                cmd.child_b_rd = 1'b1;
                state_next     = S_CHILDB;
            end
            S_CHILDB:
            begin
                cmd.grow_child = sts.b_ok;
                state_next     = S_STORE;
            end
            S_STORE:
            begin
                if (out_free)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.store)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_store_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> out_free)
        else $error("result stored while output register still full");

    a_store_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> out_valid_reg)
        else $error("stored result not presented");

    a_refit_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_kind == KIND_REFIT)) |=> (state_reg == S_LINK))
        else $error("accepted refit did not start");

    a_corner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.corner_rd |-> sts.tri_ok)
        else $error("corner read for triangle out of range");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.accept)
        else $error("transaction taken during refit");
`endif

endmodule

[rtl/core/bvh_aabb_refit.sv]
// Bottom-up bounding box refit of a fixed hierarchy over signed Q16.16 vertex
// positions. Each input transaction is a command selected by tuser: vertex
// write, triangle corner write and node record write complete on acceptance
// and leave the block ready for the next command; a refit reads the node
// record, then for a leaf walks its corners one at a time (read corner index,
// read vertex, merge), skipping triangles and vertices out of range, or for
// an internal node merges the stored boxes of both children in range. Every
// step goes through the single read port of the memory it touches. Each
// refit writes its box back to the node and emits one result transaction; a
// refit of a node index out of range emits nothing. Results sit in an output
// register, so the next command is taken while a result waits. Issue refits
// children first. Memory contents are undefined until written and need no
// clearing after reset.
module bvh_aabb_refit #(
    parameter int VERTEX_DEPTH   = 4096,
    parameter int TRIANGLE_DEPTH = 4096,
    parameter int NODE_DEPTH     = 8192,
    parameter int MAX_LEAF_TRIS  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // index[13:0], pos_x[45:14], pos_y[77:46], pos_z[109:78],
    // link_a[122:110], link_b[135:123], tri_count[139:136], zero pad
    input  logic [bvhrf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind[1:0]
    input  bvhrf_pkg::kind_t                    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // node_id[12:0], box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z (32 bits each), zero pad
    output logic [bvhrf_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import bvhrf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    bvhrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // storage and box arithmetic
    bvhrf_dp #(
        .VERTEX_DEPTH   (VERTEX_DEPTH),
        .TRIANGLE_DEPTH (TRIANGLE_DEPTH),
        .NODE_DEPTH     (NODE_DEPTH),
        .MAX_LEAF_TRIS  (MAX_LEAF_TRIS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_kind  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule

[verif/bvh_aabb_refit_checker.sv]
`timescale 1ns / 1ps

// watches both stream channels, keeps its own copy of the hierarchy and
// compares every refit transaction with the box it should carry
module bvh_aabb_refit_checker #(
    parameter int VERTEX_DEPTH   = 4096,
    parameter int TRIANGLE_DEPTH = 4096,
    parameter int NODE_DEPTH     = 8192,
    parameter int MAX_LEAF_TRIS  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [bvhrf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  bvhrf_pkg::kind_t                    s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bvhrf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output int                                  fail_count,
    output int                                  boxes_pending
);
    import bvhrf_pkg::*;

    localparam int CORNERS = 3;

    // x sits in the lowest slot, as on the bus
    typedef logic [2:0][COORD_W-1:0] point_t;
    typedef struct packed {
        point_t hi;
        point_t lo;
    } box_t;
    // node id in the lowest bits, box above it, as on the bus
    typedef struct packed {
        box_t                 bounds;
        logic [NODE_ID_W-1:0] node;
    } refit_t;

    point_t            vtx_mem    [VERTEX_DEPTH];
    logic [LINK_W-1:0] corner_mem [CORNERS * TRIANGLE_DEPTH];
    logic [LINK_W-1:0] first_mem  [NODE_DEPTH];
    logic [LINK_W-1:0] second_mem [NODE_DEPTH];
    int unsigned       tris_mem   [NODE_DEPTH];
    box_t              box_mem    [NODE_DEPTH];

    refit_t boxes_due [$];
    int     fails   = 0;
    int     waiting = 0;

    assign fail_count    = fails;
    assign boxes_pending = waiting;

    // widen a box by a signed per-axis lower and upper bound
    function automatic box_t grow_box(box_t b, point_t lo, point_t hi);
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(lo[a]) < $signed(b.lo[a]))
                b.lo[a] = lo[a];
            if ($signed(hi[a]) > $signed(b.hi[a]))
                b.hi[a] = hi[a];
        end
        return b;
    endfunction

    // update the shadow stores and queue the box a refit must produce
    function automatic void apply_command(kind_t kind, logic [IN_DATA_W-1:0] data);
        int unsigned       idx;
        int unsigned       cnt;
        int unsigned       tri_no;
        int unsigned       v;
        point_t            pos;
        logic [LINK_W-1:0] la;
        logic [LINK_W-1:0] lb;
        box_t              b;
        idx = data[INDEX_W-1:0];
        pos = data[INDEX_W +: VTX_W];
        la  = data[INDEX_W + VTX_W +: LINK_W];
        lb  = data[INDEX_W + VTX_W + LINK_W +: LINK_W];
        cnt = data[INDEX_W + VTX_W + 2 * LINK_W +: COUNT_W];
        case (kind)
            KIND_VERTEX:
                if (idx < VERTEX_DEPTH)
                    vtx_mem[idx] = pos;
            KIND_CORNER:
                if (idx < CORNERS * TRIANGLE_DEPTH)
                    corner_mem[idx] = la;
            KIND_NODE:
                if (idx < NODE_DEPTH)
                begin
                    first_mem[idx]  = la;
                    second_mem[idx] = lb;
                    tris_mem[idx]   = (cnt > MAX_LEAF_TRIS) ? MAX_LEAF_TRIS : cnt;
                end
            KIND_REFIT:
                if (idx < NODE_DEPTH)
                begin
                    b.lo = {3{EMPTY_MIN}};
                    b.hi = {3{EMPTY_MAX}};
                    if (tris_mem[idx] != 0)
                    begin
                        // leaf: every corner of every triangle in range
                        for (int k = 0; k < tris_mem[idx]; k++)
                        begin
                            tri_no = first_mem[idx] + k;
                            if (tri_no < TRIANGLE_DEPTH)
                            begin
                                for (int c = 0; c < CORNERS; c++)
                                begin
                                    v = corner_mem[tri_no * CORNERS + c];
                                    if (v < VERTEX_DEPTH)
                                        b = grow_box(b, vtx_mem[v], vtx_mem[v]);
                                end
                            end
                        end
                    end
                    else
                    begin
                        // internal: union of the stored child boxes in range
                        if (first_mem[idx] < NODE_DEPTH)
                            b = grow_box(b, box_mem[first_mem[idx]].lo,
                                         box_mem[first_mem[idx]].hi);
                        if (second_mem[idx] < NODE_DEPTH)
                            b = grow_box(b, box_mem[second_mem[idx]].lo,
                                         box_mem[second_mem[idx]].hi);
                    end
                    box_mem[idx] = b;
                    boxes_due.push_back({b, NODE_ID_W'(idx)});
                end
        endcase
    endfunction

    function automatic void check_field(string name, logic [COORD_W-1:0] want,
                                        logic [COORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endfunction

    // sample both channels at the edge where the transactions complete
    always @(posedge clk)
    begin
        refit_t got;
        refit_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                apply_command(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[NODE_ID_W + BOX_W - 1:0];
                if (boxes_due.size() == 0)
                begin
                    $error("box for node %0d arrived with none expected", got.node);
                    fails++;
                end
                else
                begin
                    want = boxes_due.pop_front();
                    check_field("node_id", COORD_W'(want.node), COORD_W'(got.node));
                    for (int a = 0; a < 3; a++)
                    begin
                        check_field($sformatf("box_min_%c", 8'h78 + a),
                                    want.bounds.lo[a], got.bounds.lo[a]);
                        check_field($sformatf("box_max_%c", 8'h78 + a),
                                    want.bounds.hi[a], got.bounds.hi[a]);
                    end
                end
            end
            waiting = boxes_due.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bvhrf_pkg::*;

    localparam int VERTEX_DEPTH   = 4096;
    localparam int TRIANGLE_DEPTH = 4096;
    localparam int NODE_DEPTH     = 8192;
    localparam int MAX_LEAF_TRIS  = 8;
    localparam int CORNERS        = 3;
    localparam int CORNER_DEPTH   = CORNERS * TRIANGLE_DEPTH;
    localparam int INDEX_LIMIT    = 12288;
    localparam int LINK_MAX       = (1 << LINK_W) - 1;
    localparam int ITEMS_TARGET   = 1150;
    localparam int CALM_TAIL      = 120;
    localparam int HOLD_AFTER     = 40;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 100;
    localparam int CYCLE_LIMIT    = 1_000_000;

    typedef struct {
        kind_t              kind;
        logic [INDEX_W-1:0] index;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [LINK_W-1:0]  link_a;
        logic [LINK_W-1:0]  link_b;
        logic [COUNT_W-1:0] tri_count;
    } command_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    kind_t                 s_axis_tuser  = KIND_VERTEX;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int boxes_pending;
    int results_seen = 0;
    int cycles       = 0;
    bit calm         = 1'b0;

    command_t cmd_q [$];

    // what the command stream has written so far, so no refit reads an unwritten entry
    bit          vtx_set    [VERTEX_DEPTH];
    bit          corner_set [CORNER_DEPTH];
    int unsigned corner_vtx [CORNER_DEPTH];
    bit          rec_set    [NODE_DEPTH];
    int unsigned rec_first  [NODE_DEPTH];
    int unsigned rec_second [NODE_DEPTH];
    int unsigned rec_tris   [NODE_DEPTH];
    bit          box_set    [NODE_DEPTH];
    int unsigned known_nodes [$];

    bvh_aabb_refit #(
        .VERTEX_DEPTH   (VERTEX_DEPTH),
        .TRIANGLE_DEPTH (TRIANGLE_DEPTH),
        .NODE_DEPTH     (NODE_DEPTH),
        .MAX_LEAF_TRIS  (MAX_LEAF_TRIS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bvh_aabb_refit_checker #(
        .VERTEX_DEPTH   (VERTEX_DEPTH),
        .TRIANGLE_DEPTH (TRIANGLE_DEPTH),
        .NODE_DEPTH     (NODE_DEPTH),
        .MAX_LEAF_TRIS  (MAX_LEAF_TRIS)
    ) refit_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .boxes_pending (boxes_pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // extremes, full-range values and small values around the origin
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // unused fields of a command carry random bits
    function automatic command_t blank_command(kind_t kind, int unsigned idx);
        command_t c;
        c.kind      = kind;
        c.index     = idx;
        c.pos_x     = $urandom();
        c.pos_y     = $urandom();
        c.pos_z     = $urandom();
        c.link_a    = $urandom();
        c.link_b    = $urandom();
        c.tri_count = $urandom();
        return c;
    endfunction

    function automatic void add_vertex(int unsigned idx, logic [COORD_W-1:0] x,
                                       logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
        command_t c;
        c       = blank_command(KIND_VERTEX, idx);
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        if (idx < VERTEX_DEPTH)
            vtx_set[idx] = 1'b1;
        cmd_q.push_back(c);
    endfunction

    function automatic void add_corner(int unsigned slot, int unsigned vtx);
        command_t c;
        c        = blank_command(KIND_CORNER, slot);
        c.link_a = vtx;
        if (slot < CORNER_DEPTH)
        begin
            corner_set[slot] = 1'b1;
            corner_vtx[slot] = vtx;
        end
        cmd_q.push_back(c);
    endfunction

    function automatic void add_node(int unsigned idx, int unsigned a, int unsigned b,
                                     int unsigned n);
        command_t c;
        c           = blank_command(KIND_NODE, idx);
        c.link_a    = a;
        c.link_b    = b;
        c.tri_count = n;
        if (idx < NODE_DEPTH)
        begin
            rec_set[idx]    = 1'b1;
            rec_first[idx]  = a;
            rec_second[idx] = b;
            rec_tris[idx]   = (n > MAX_LEAF_TRIS) ? MAX_LEAF_TRIS : n;
            known_nodes.push_back(idx);
        end
        cmd_q.push_back(c);
    endfunction

    function automatic void add_refit(int unsigned idx);
        if (idx < NODE_DEPTH)
            box_set[idx] = 1'b1;
        cmd_q.push_back(blank_command(KIND_REFIT, idx));
    endfunction

    // a refit is legal when everything it reads has been written
    function automatic bit refit_safe(int unsigned idx);
        int unsigned tri_no;
        int unsigned slot;
        if (idx >= NODE_DEPTH)
            return 1'b1;
        if (!rec_set[idx])
            return 1'b0;
        if (rec_tris[idx] == 0)
            return (rec_first[idx] >= NODE_DEPTH || box_set[rec_first[idx]]) &&
                   (rec_second[idx] >= NODE_DEPTH || box_set[rec_second[idx]]);
        for (int k = 0; k < rec_tris[idx]; k++) begin
            tri_no = rec_first[idx] + k;
            if (tri_no < TRIANGLE_DEPTH)
            begin
                for (int c = 0; c < CORNERS; c++) begin
                    slot = tri_no * CORNERS + c;
                    if (!corner_set[slot])
                        return 1'b0;
                    if (corner_vtx[slot] < VERTEX_DEPTH && !vtx_set[corner_vtx[slot]])
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // command generation, reset and the sender
    initial
    begin
        command_t    item;
        int unsigned nv, vb, nt, tri_base, next_id, n, i, frames, l, r, pick;
        int unsigned gap_odds, sent;
        int unsigned level [$];
        int unsigned upper [$];
        int unsigned order [$];

        // directed: store extremes, saturated count, ranges running off each store
        add_vertex(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        add_vertex(VERTEX_DEPTH - 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_vertex(1, pick_coord(), pick_coord(), pick_coord());
        add_vertex(INDEX_LIMIT - 1, pick_coord(), pick_coord(), pick_coord());
        add_corner(0, 0);
        add_corner(1, VERTEX_DEPTH - 1);
        add_corner(2, 1);
        // last triangle of the store, one corner naming a vertex beyond it
        add_corner(CORNER_DEPTH - 3, 1);
        add_corner(CORNER_DEPTH - 2, 0);
        add_corner(CORNER_DEPTH - 1, LINK_MAX);
        add_node(0, 0, 0, 1);
        // count above the limit, triangle run past the end of the store
        add_node(NODE_DEPTH - 1, TRIANGLE_DEPTH - 1, LINK_MAX, 15);
        // all triangles beyond the store: empty box
        add_node(5, LINK_MAX, 0, MAX_LEAF_TRIS);
        add_node(INDEX_LIMIT - 1, 0, 0, 1);
        add_refit(0);
        add_refit(NODE_DEPTH - 1);
        add_refit(5);
        add_node(6, 0, NODE_DEPTH - 1, 0);
        add_refit(6);
        add_node(9, 5, 5, 0);
        add_refit(9);
        add_refit(INDEX_LIMIT - 1);
        add_refit(NODE_DEPTH);

        // random scenes: load a small mesh and tree, refit over a few frames
        while (cmd_q.size() < ITEMS_TARGET) begin
            nv = $urandom_range(3, 12);
            vb = $urandom_range(0, VERTEX_DEPTH - nv);
            for (i = 0; i < nv; i++)
                add_vertex(vb + i, pick_coord(), pick_coord(), pick_coord());
            nt = $urandom_range(1, 12);
            tri_base = ($urandom_range(0, 5) == 0) ? TRIANGLE_DEPTH - nt
                                                   : $urandom_range(0, TRIANGLE_DEPTH - nt);
            for (i = 0; i < CORNERS * nt; i++)
                add_corner(CORNERS * tri_base + i,
                           ($urandom_range(0, 15) == 0) ? $urandom_range(VERTEX_DEPTH, LINK_MAX)
                                                        : vb + $urandom_range(0, nv - 1));
            next_id = $urandom_range(0, NODE_DEPTH - 2 * nt);
            level.delete();
            order.delete();
            // leaves over consecutive triangle runs
            for (i = 0; i < nt; i += n) begin
                n = $urandom_range(1, (nt - i < MAX_LEAF_TRIS) ? nt - i : MAX_LEAF_TRIS);
                // a leaf ending on the last triangle of the store may claim more
                if (tri_base + i + n == TRIANGLE_DEPTH && $urandom_range(0, 1) == 1)
                    n = $urandom_range(n, MAX_LEAF_TRIS);
                add_node(next_id, tri_base + i, $urandom_range(0, LINK_MAX), n);
                level.push_back(next_id);
                order.push_back(next_id);
                next_id++;
            end
            // pair nodes level by level up to one root
            while (level.size() > 1) begin
                upper.delete();
                while (level.size() >= 2) begin
                    l = level.pop_front();
                    r = level.pop_front();
                    if ($urandom_range(0, 1) == 1)
                        add_node(next_id, r, l, 0);
                    else
                        add_node(next_id, l, r, 0);
                    upper.push_back(next_id);
                    order.push_back(next_id);
                    next_id++;
                end
                if (level.size() == 1)
                    upper.push_back(level.pop_front());
                level = upper;
            end
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if (f != 0)
                begin
                    for (i = 0; i < nv; i++)
                        if ($urandom_range(0, 3) != 0)
                            add_vertex(vb + i, pick_coord(), pick_coord(), pick_coord());
                end
                foreach (order[j])
                    if (refit_safe(order[j]))
                        add_refit(order[j]);
            end
            // stray writes and refits between scenes
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 4))
                    0: add_vertex($urandom_range(0, INDEX_LIMIT - 1),
                                  pick_coord(), pick_coord(), pick_coord());
                    1: add_corner($urandom_range(0, CORNER_DEPTH - 1),
                                  $urandom_range(0, LINK_MAX));
                    2: add_node($urandom_range(0, INDEX_LIMIT - 1), $urandom_range(0, LINK_MAX),
                                $urandom_range(0, LINK_MAX), $urandom_range(0, MAX_LEAF_TRIS));
                    default:
                    begin
                        if ($urandom_range(0, 3) == 0 || known_nodes.size() == 0)
                            pick = $urandom_range(0, INDEX_LIMIT - 1);
                        else
                            pick = known_nodes[$urandom_range(0, known_nodes.size() - 1)];
                        if (refit_safe(pick))
                            add_refit(pick);
                    end
                endcase
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender with bursty gaps whose density changes along the run
        sent     = 0;
        gap_odds = 0;
        while (cmd_q.size() != 0) begin
            item = cmd_q.pop_front();
            if (sent % 64 == 0)
                gap_odds = $urandom_range(0, 3);
            sent++;
            calm = (cmd_q.size() < CALM_TAIL);
            if (!calm && gap_odds != 0 && $urandom_range(0, 2 * gap_odds) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= item.kind;
            s_axis_tdata  <= {4'd0, item.tri_count, item.link_b, item.link_a,
                              item.pos_z, item.pos_y, item.pos_x, item.index};
            @(posedge clk);
            while (!s_axis_tready) @(posedge clk);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        // drain what is still in flight, then give the verdict
        while (boxes_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stall bursts and one long hold-off to back the block up
    initial
    begin
        int unsigned odds;
        int unsigned tick;
        bit          held;
        odds = 0;
        tick = 0;
        held = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            tick++;
            if (tick % 128 == 0)
                odds = $urandom_range(0, 3);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && odds != 0 && $urandom_range(0, 2 * odds) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // count delivered boxes for the hold-off trigger
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            results_seen <= results_seen + 1;
    end

    // watchdog
    initial
    begin
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

[sim.f]
rtl/core/bvhrf_pkg.sv
rtl/core/bvhrf_dp.sv
rtl/core/bvhrf_ctrl.sv
rtl/core/bvh_aabb_refit.sv
verif/bvh_aabb_refit_checker.sv
verif/tb.sv
